@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files, included by directed_graph_reachability.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, muted while rst_n is low
`define DGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check on clk that also holds during reset
`define DGR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/dgr_pkg.sv @@
// package for the directed graph reachability block: sizes, codes, states, helpers
package dgr_pkg;

  localparam int MAX_V  = 64;
  localparam int VID_W  = 6;
  localparam int CNT_W  = 7;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int GRP    = 8;
  localparam int NGRP   = MAX_V / GRP;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_VERTEX_COUNT = 1'b0;

  localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(MAX_V);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_Q_ISSUE,
    ST_Q_MERGE,
    ST_RESP
  } dgr_state_t;

  // lowest set bit, found group first then bit within the group
  function automatic logic [VID_W-1:0] first_set(input logic [MAX_V-1:0] v);
    logic [NGRP-1:0] any;
    logic [2:0]      g;
    logic [2:0]      b;
    logic [GRP-1:0]  sel;
    for (int i = 0; i < NGRP; i++) begin
      any[i] = |v[i*GRP +: GRP];
    end
    g = '0;
    for (int i = NGRP - 1; i >= 0; i--) begin
      if (any[i]) g = 3'(i);
    end
    sel = v[g*GRP +: GRP];
    b = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (sel[i]) b = 3'(i);
    end
    return {g, b};
  endfunction

endpackage

@@ hw/rtl/directed_graph_reachability.sv @@
// directed graph reachability: adjacency memory, frontier search, stream and apb ports
//
//  channel   | direction | handshake              | contents
//  in_*      | slave     | in_tvalid / in_tready   | tuser command, tdata source and target
//  out_*     | master    | out_tvalid / out_tready | tdata path_exists, index_error
//  cfg_*     | apb slave | psel, penable, pready   | vertex_count at byte address 0
//
// an add item reads the tail row, then writes it back with the head bit set.
// a query is accepted, expands one vertex at a time (row read from the adjacency
// memory, then merge) and ends with a response; it stops early once the target is
// reached. the response state repeats while the output register is full, and a
// result waits there while the next item is taken.
// reset clears the 64 row valid bits at once, so no clearing pass.
`include "assert_macros.svh"

module directed_graph_reachability (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // [5:0] source_vertex, [11:6] target_vertex
  input  logic                        in_tuser,   // [0] command
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [0] path_exists, [1] index_error
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dgr_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [dgr_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [dgr_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import dgr_pkg::*;

  dgr_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  vcount_r;
  logic [CNT_W-1:0]  eff_cnt;
  logic [MAX_V-1:0]  vmask;

  logic [MAX_V-1:0]  adj_mem [MAX_V];
  logic [MAX_V-1:0]  row_vld_r;
  logic [MAX_V-1:0]  rdata_r;
  logic              rvld_r;

  logic [VID_W-1:0]  src_r, dst_r;
  logic [MAX_V-1:0]  reached_r, pending_r;
  logic              res_path_r, res_err_r;
  logic              out_valid_r, out_path_r, out_err_r;

  logic              in_acc, cfg_we, out_free, out_load;
  logic [VID_W-1:0]  in_src, in_dst, pick, rd_addr;
  logic              src_ok, dst_ok, q_ok, edge_ok;
  logic              mem_re, mem_we;
  logic [MAX_V-1:0]  row_data, new_bits, reached_upd, pending_upd, wdata;
  logic              hit;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                      (cfg_paddr[2] == REG_VERTEX_COUNT);
  assign cfg_prdata = (cfg_paddr[2] == REG_VERTEX_COUNT) ?
                      {{(DATA_W-CNT_W){1'b0}}, vcount_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
    end else if (cfg_we) begin
      vcount_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  assign eff_cnt = (vcount_r > CNT_W'(MAX_V)) ? CNT_W'(MAX_V) : vcount_r;

  always_comb begin
    for (int i = 0; i < MAX_V; i++) begin
      vmask[i] = (CNT_W'(i) < eff_cnt);
    end
  end

  // datapath terms
  assign in_src   = in_tdata[VID_W-1:0];
  assign in_dst   = in_tdata[2*VID_W-1:VID_W];
  assign in_acc   = in_tvalid & in_tready;
  assign src_ok   = ({1'b0, in_src} < eff_cnt);
  assign dst_ok   = ({1'b0, in_dst} < eff_cnt);
  assign q_ok     = src_ok & dst_ok;
  assign edge_ok  = src_ok & dst_ok;
  assign out_free = ~out_valid_r | out_tready;

  assign pick        = first_set(pending_r);
  assign row_data    = rdata_r & {MAX_V{rvld_r}};
  assign new_bits    = row_data & vmask & ~reached_r;
  assign reached_upd = reached_r | new_bits;
  assign pending_upd = pending_r | new_bits;
  assign hit         = reached_upd[dst_r];
  assign wdata       = row_data | (MAX_V'(1) << dst_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == CMD_ADD) begin
            state_nxt = edge_ok ? ST_ADD_WR : ST_IDLE;
          end else if (!q_ok || (in_src == in_dst)) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_Q_ISSUE;
          end
        end
      end
      ST_ADD_WR:  state_nxt = ST_IDLE;
      ST_Q_ISSUE: state_nxt = ST_Q_MERGE;
      ST_Q_MERGE: begin
        if (hit || !(|pending_upd)) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_Q_ISSUE;
        end
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    rd_addr   = in_src;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        mem_re    = in_tvalid;
      end
      ST_ADD_WR:  mem_we = 1'b1;
      ST_Q_ISSUE: begin
        mem_re  = 1'b1;
        rd_addr = pick;
      end
      ST_Q_MERGE: ;
      ST_RESP:    out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // adjacency memory, one row per tail vertex, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      adj_mem[src_r] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= adj_mem[rd_addr];
    end
  end

  // row valid bits stand in for clearing the memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rvld_r    <= 1'b0;
    end else begin
      if (mem_we) row_vld_r[src_r] <= 1'b1;
      if (mem_re) rvld_r <= row_vld_r[rd_addr];
    end
  end

  // search sets and item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_r <= '0;
      pending_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_tuser == CMD_QUERY) && q_ok) begin
            reached_r <= MAX_V'(1) << in_src;
            pending_r <= MAX_V'(1) << in_src;
          end
        end
        ST_Q_ISSUE: pending_r[pick] <= 1'b0;
        ST_Q_MERGE: begin
          reached_r <= reached_upd;
          pending_r <= pending_upd;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      src_r      <= in_src;
      dst_r      <= in_dst;
      res_path_r <= q_ok & (in_src == in_dst);
      res_err_r  <= ~q_ok;
    end else if (state_r == ST_Q_MERGE) begin
      res_path_r <= hit;
      res_err_r  <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_path_r <= res_path_r;
      out_err_r  <= res_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_err_r, out_path_r};

  // checks
  `DGR_ASSERT(a_row_marked, mem_we |=> row_vld_r[$past(src_r)], "written row not marked valid")
  `DGR_ASSERT(a_pend_in_reached, (pending_r & ~reached_r) == '0, "pending vertex not reached")
  `DGR_ASSERT(a_reach_grows, (state_r == ST_Q_MERGE) |=> ((reached_r & $past(reached_r)) == $past(reached_r)), "reached set lost a vertex")
  `DGR_ASSERT(a_err_no_path, out_valid_r |-> !(out_path_r && out_err_r), "index error with path flag")

endmodule
